// File: src/life_generation_row_stream_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the life generation row stream unit
// Concurrent checks on clk, disabled while rst_n is low; empty when SYNTH.
// ---------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ROW_STREAM_UNIT_ASSERT_SVH
`define LIFE_GENERATION_ROW_STREAM_UNIT_ASSERT_SVH

`ifndef SYNTH
// property that must hold at every edge
`define LGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// non-overlapping implication from antecedent to consequent
`define LGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LGR_ASSERT(lbl, prop, msg)
`define LGR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/lgr_pkg.sv
// ---------------------------------------------------------------------------
// lgr_pkg
// Shared constants, types and the B3/S23 rule for the row stream unit.
// ---------------------------------------------------------------------------
package lgr_pkg;

  localparam int LGR_MAX_WIDTH  = 64;  // columns built, 3..64
  localparam int LGR_DATA_W     = 64;  // row field width
  localparam int LGR_WIDTH_W    = 7;   // grid_width register
  localparam int LGR_FIFO_DEPTH = 4;   // power of two, at least 2
  localparam int LGR_PTR_W      = $clog2(LGR_FIFO_DEPTH);
  localparam int LGR_CNT_W      = LGR_PTR_W + 1;
  localparam int LGR_ENTRY_W    = LGR_DATA_W + 1;  // next_cells, last_of_frame

  // one column's view as seen by its neighbors
  typedef struct packed {
    logic row;     // incoming row bit, masked
    logic upper;   // stored upper row bit
    logic middle;  // stored middle row bit
  } lgr_col_t;

  // per-word control shared by every cell
  typedef struct packed {
    logic accept;
    logic holding;
    logic last;
  } lgr_cell_ctrl_t;

  // output queue status
  typedef struct packed {
    logic [LGR_CNT_W-1:0] count;
    logic                 room2;  // two free slots
  } lgr_fifo_stat_t;

  function automatic logic lgr_rule(input logic [3:0] cnt, input logic alive);
    return (cnt == 4'd3) || ((cnt == 4'd2) && alive);
  endfunction

endpackage

// File: src/lgr_cell.sv
// ---------------------------------------------------------------------------
// lgr_cell
// One column: holds its upper/middle row bits and evaluates both results.
// ---------------------------------------------------------------------------
module lgr_cell
  import lgr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  lgr_cell_ctrl_t ctrl,
  input  logic           mask,
  input  logic           row_in,
  input  lgr_col_t       west,
  input  lgr_col_t       east,
  output lgr_col_t       own,
  output logic           res_mid,  // next state of stored middle row
  output logic           res_new   // next state of incoming row, nothing below
);

  logic upper_r, upper_nxt;
  logic middle_r, middle_nxt;
  logic row_m;
  logic [3:0] cnt_mid, cnt_new;
  logic ab_w, ab_c, ab_e;

  assign row_m = row_in & mask;
  assign own   = '{row: row_m, upper: upper_r, middle: middle_r};

  // middle row sees stored upper above and incoming row below
  assign cnt_mid = 4'(west.upper) + 4'(upper_r) + 4'(east.upper)
                 + 4'(west.middle) + 4'(east.middle)
                 + 4'(west.row) + 4'(row_m) + 4'(east.row);
  assign res_mid = lgr_rule(cnt_mid, middle_r) & mask;

  // incoming row sees the stored middle above (if held) and dead below
  assign ab_w = west.middle & ctrl.holding;
  assign ab_c = middle_r & ctrl.holding;
  assign ab_e = east.middle & ctrl.holding;
  assign cnt_new = 4'(ab_w) + 4'(ab_c) + 4'(ab_e) + 4'(west.row) + 4'(east.row);
  assign res_new = lgr_rule(cnt_new, row_m) & mask;

  always_comb begin
    upper_nxt  = upper_r;
    middle_nxt = middle_r;
    if (ctrl.accept) begin
      if (ctrl.last) begin
        upper_nxt  = 1'b0;
        middle_nxt = 1'b0;
      end else begin
        upper_nxt  = ctrl.holding & middle_r;
        middle_nxt = row_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r  <= 1'b0;
      middle_r <= 1'b0;
    end else begin
      upper_r  <= upper_nxt;
      middle_r <= middle_nxt;
    end
  end

endmodule

// File: src/lgr_out_fifo.sv
// ---------------------------------------------------------------------------
// lgr_out_fifo
// Small result queue; takes up to two words per cycle, drains one on rd_ready.
// ---------------------------------------------------------------------------
module lgr_out_fifo
  import lgr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr0_en,
  input  logic [LGR_ENTRY_W-1:0] wr0_data,
  input  logic                   wr1_en,   // only with wr0_en
  input  logic [LGR_ENTRY_W-1:0] wr1_data,
  input  logic                   rd_ready,
  output logic                   rd_valid,
  output logic [LGR_ENTRY_W-1:0] rd_data,
  output lgr_fifo_stat_t         stat
);

  logic [LGR_ENTRY_W-1:0] mem_r [LGR_FIFO_DEPTH];
  logic [LGR_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [LGR_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LGR_CNT_W-1:0]   count_r, count_nxt;
  logic [LGR_PTR_W-1:0]   wr_ptr_p1;
  logic [LGR_CNT_W-1:0]   n_wr;
  logic                   pop;

  assign rd_valid  = (count_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];
  assign pop       = rd_valid & rd_ready;
  assign wr_ptr_p1 = wr_ptr_r + LGR_PTR_W'(1);
  assign n_wr      = LGR_CNT_W'(wr0_en) + LGR_CNT_W'(wr1_en);

  assign stat.count = count_r;
  assign stat.room2 = (count_r <= LGR_CNT_W'(LGR_FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + LGR_PTR_W'(n_wr);
    rd_ptr_nxt = rd_ptr_r + LGR_PTR_W'(pop);
    count_nxt  = count_r + n_wr - LGR_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (wr0_en) begin
      mem_r[wr_ptr_r] <= wr0_data;
    end
    if (wr1_en) begin
      mem_r[wr_ptr_p1] <= wr1_data;
    end
  end

endmodule

// File: src/life_generation_row_stream_unit.sv
// ---------------------------------------------------------------------------
// life_generation_row_stream_unit
// One B3/S23 generation over a grid streamed one row per word.
// ---------------------------------------------------------------------------
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-----------------------------------
//  in       | in  | in_tvalid/in_tready   | tdata row_cells, tlast last_row
//  out      | out | out_tvalid/out_tready | tdata next_cells, tlast last_of_frame
//  cfg      | in  | cfg_we                | cfg_wdata grid_width
//
//  One row word is taken per cycle while in_tready is high; its result word
//  can leave the cycle after the row below it is taken. A bottom row writes
//  its own result too; after a held row it writes two queue words at once.
//  in_tready comes from the output queue alone: low when fewer than two of its
//  four slots are free. A stalled out side fills the queue, nothing more.
//  Reset (rst_n low, synchronous) empties the queue, clears held rows, width 64.
//
module life_generation_row_stream_unit
  import lgr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input rows
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [LGR_DATA_W-1:0]  in_tdata,   // [63:0] row_cells
  input  logic                   in_tlast,   // last_row
  // result rows
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [LGR_DATA_W-1:0]  out_tdata,  // [63:0] next_cells
  output logic                   out_tlast,  // last_of_frame
  // configuration
  input  logic                   cfg_we,
  input  logic [LGR_WIDTH_W-1:0] cfg_wdata   // grid_width
);

`include "life_generation_row_stream_unit_assert.svh"

  // -------------------------------------------------------------------------
  // Control state
  // -------------------------------------------------------------------------
  logic [LGR_WIDTH_W-1:0] width_r, width_nxt;
  logic                   holding_r, holding_nxt;
  logic                   accept;
  lgr_cell_ctrl_t         ctrl;
  lgr_fifo_stat_t         fstat;

  assign accept = in_tvalid & in_tready;
  assign ctrl   = '{accept: accept, holding: holding_r, last: in_tlast};

  always_comb begin
    width_nxt   = cfg_we ? cfg_wdata : width_r;
    holding_nxt = holding_r;
    if (accept) begin
      holding_nxt = ~in_tlast;  // a bottom row ends the frame
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= LGR_WIDTH_W'(64);
      holding_r <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      holding_r <= holding_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Row of cells, one per column; each reads its two neighbors' bits
  // -------------------------------------------------------------------------
  lgr_col_t               col  [LGR_MAX_WIDTH];
  lgr_col_t               west [LGR_MAX_WIDTH];
  lgr_col_t               east [LGR_MAX_WIDTH];
  logic [LGR_MAX_WIDTH-1:0] mask;
  logic [LGR_MAX_WIDTH-1:0] res_mid, res_new;

  for (genvar j = 0; j < LGR_MAX_WIDTH; j++) begin : g_col
    // column in use when j < grid_width
    assign mask[j] = (width_r > LGR_WIDTH_W'(j));

    if (j == 0) begin : g_w_edge
      assign west[j] = '0;  // left of column 0 is dead
    end else begin : g_w
      assign west[j] = col[j-1];
    end

    if (j == LGR_MAX_WIDTH - 1) begin : g_e_edge
      assign east[j] = '0;  // right of the last built column is dead
    end else begin : g_e
      assign east[j] = col[j+1];
    end

    lgr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .mask    (mask[j]),
      .row_in  (in_tdata[j]),
      .west    (west[j]),
      .east    (east[j]),
      .own     (col[j]),
      .res_mid (res_mid[j]),
      .res_new (res_new[j])
    );
  end

  // -------------------------------------------------------------------------
  // Result words: held middle row first, then the bottom row's own result
  // -------------------------------------------------------------------------
  logic [LGR_DATA_W-1:0]  mid_word, new_word;
  logic                   wr0_en, wr1_en;
  logic [LGR_ENTRY_W-1:0] wr0_data, wr1_data;
  logic [LGR_ENTRY_W-1:0] rd_data;

  always_comb begin
    mid_word = '0;
    new_word = '0;
    mid_word[LGR_MAX_WIDTH-1:0] = res_mid;
    new_word[LGR_MAX_WIDTH-1:0] = res_new;
  end

  assign wr0_en   = accept & (holding_r | in_tlast);
  assign wr1_en   = accept & holding_r & in_tlast;
  assign wr0_data = holding_r ? {1'b0, mid_word} : {1'b1, new_word};
  assign wr1_data = {1'b1, new_word};

  lgr_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr0_en   (wr0_en),
    .wr0_data (wr0_data),
    .wr1_en   (wr1_en),
    .wr1_data (wr1_data),
    .rd_ready (out_tready),
    .rd_valid (out_tvalid),
    .rd_data  (rd_data),
    .stat     (fstat)
  );

  assign in_tready = fstat.room2;
  assign out_tdata = rd_data[LGR_DATA_W-1:0];
  assign out_tlast = rd_data[LGR_DATA_W];

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `LGR_ASSERT(a_fifo_bound, fstat.count <= LGR_CNT_W'(LGR_FIFO_DEPTH), "queue overflow")
  `LGR_ASSERT(a_ready_room, !in_tready || fstat.count <= LGR_CNT_W'(LGR_FIFO_DEPTH - 2), "no room")
  `LGR_ASSERT(a_valid_count, out_tvalid == (fstat.count != '0), "valid vs queue fill")
  `LGR_ASSERT_NEXT(a_last_clears, accept && in_tlast, !holding_r && out_tvalid, "no flush")

endmodule
